### hdl/dclk_pkg.sv
// Shared types, constants and helper functions for the digital clock block.
// Used by every module under hdl/; depends on nothing else.

package dclk_pkg;

  // Last value of each time field before it wraps.
  localparam logic [9:0] MS_LAST  = 10'd999;
  localparam logic [5:0] SEC_LAST = 6'd59;
  localparam logic [5:0] MIN_LAST = 6'd59;
  localparam logic [4:0] HR_LAST  = 5'd23;

  // Beat widths on the stream ports.
  localparam int IN_W  = 8;
  localparam int OUT_W = 48;

  // View codes as they appear on the result beat.
  localparam logic [1:0] VIEW_HM  = 2'd0;
  localparam logic [1:0] VIEW_SC  = 2'd1;
  localparam logic [1:0] VIEW_MOD = 2'd2;

  // Mode machine states, one-hot.
  typedef enum logic [2:0] {
    MODE_HM  = 3'b001,
    MODE_SC  = 3'b010,
    MODE_MOD = 3'b100
  } mode_t;

  // Flags carried by one input beat.
  typedef struct packed {
    logic tick;
    logic mode_rel;
    logic modify_rel;
    logic hour_rel;
    logic minute_rel;
  } ev_t;

  // Controls from the mode machine to the counters and the display.
  typedef struct packed {
    logic hour_step;
    logic minute_step;
    logic show_hm;
    logic show_sc;
  } set_t;

  // Time of day after the update.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;
  } tod_t;

  // Divide a millisecond count (below 1024) by ten via a reciprocal multiply.
  function automatic logic [6:0] div10(input logic [9:0] m);
    logic [17:0] p;
    p = {8'd0, m} * 18'd205;
    return p[17:11];
  endfunction

  // Two fields shown as a four-digit number: hi*100 + lo.
  function automatic logic [13:0] pair100(input logic [5:0] hi, input logic [6:0] lo);
    logic [13:0] p;
    p = {8'd0, hi} * 14'd100;
    return p + {7'd0, lo};
  endfunction

  // Encode a mode state for the result beat.
  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_SC:  c = VIEW_SC;
      MODE_MOD: c = VIEW_MOD;
      default:  c = VIEW_HM;
    endcase
    return c;
  endfunction

endpackage

### hdl/dclk_time.sv
// Cascaded time-of-day counter with colon toggle and setting steps.
// Depends on dclk_pkg.

module dclk_time
  import dclk_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  tick,
  input  set_t  set,
  output tod_t  tod_nxt,
  output logic  colon_nxt
);

  logic [9:0] millis_r;
  logic [5:0] seconds_r;
  logic [5:0] minutes_r;
  logic [4:0] hours_r;
  logic       colon_r;

  logic       ms_wrap;
  logic       sec_wrap;
  logic       min_wrap;
  logic [5:0] minutes_tick;
  logic [4:0] hours_tick;

  // Tick cascade: each field wraps and carries into the next.
  always_comb begin
    ms_wrap  = tick && (millis_r == MS_LAST);
    sec_wrap = ms_wrap && (seconds_r == SEC_LAST);
    min_wrap = sec_wrap && (minutes_r == MIN_LAST);

    tod_nxt.millis  = tick ? (ms_wrap ? 10'd0 : millis_r + 10'd1) : millis_r;
    tod_nxt.seconds = ms_wrap ? (sec_wrap ? 6'd0 : seconds_r + 6'd1) : seconds_r;
    minutes_tick    = sec_wrap ? (min_wrap ? 6'd0 : minutes_r + 6'd1) : minutes_r;
    hours_tick      = min_wrap ? ((hours_r == HR_LAST) ? 5'd0 : hours_r + 5'd1) : hours_r;

    // Setting buttons step their own field without any carry.
    tod_nxt.hours   = set.hour_step ?
                      ((hours_tick == HR_LAST) ? 5'd0 : hours_tick + 5'd1) : hours_tick;
    tod_nxt.minutes = set.minute_step ?
                      ((minutes_tick == MIN_LAST) ? 6'd0 : minutes_tick + 6'd1) :
                      minutes_tick;

    colon_nxt = colon_r ^ ms_wrap;
  end

  // State update, once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      millis_r  <= '0;
      seconds_r <= '0;
      minutes_r <= '0;
      hours_r   <= '0;
      colon_r   <= 1'b0;
    end else if (adv) begin
      millis_r  <= tod_nxt.millis;
      seconds_r <= tod_nxt.seconds;
      minutes_r <= tod_nxt.minutes;
      hours_r   <= tod_nxt.hours;
      colon_r   <= colon_nxt;
    end
  end

  // The counters never leave their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (millis_r <= MS_LAST) && (seconds_r <= SEC_LAST) &&
    (minutes_r <= MIN_LAST) && (hours_r <= HR_LAST))
    else $error("time counter out of range");

  // The colon only flips when the milliseconds roll over.
  a_colon: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && tick && (millis_r == MS_LAST)) |=> $stable(colon_r))
    else $error("colon toggled without a second rollover");

  // Without a tick the seconds hold.
  a_sec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !tick) |=> $stable(seconds_r) && $stable(millis_r))
    else $error("seconds moved without a tick");

endmodule

### hdl/dclk_mode.sv
// View and modify mode machine; drives the setting steps and display refresh.
// Depends on dclk_pkg.

module dclk_mode
  import dclk_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  ev_t   ev,
  output mode_t mode_nxt,
  output set_t  set
);

  mode_t mode_r;

  // Next mode; in the hours:minutes view a modify release wins.
  always_comb begin
    case (mode_r)
      MODE_SC:  mode_nxt = ev.mode_rel ? MODE_HM : MODE_SC;
      MODE_MOD: mode_nxt = ev.modify_rel ? MODE_HM : MODE_MOD;
      default: begin
        if (ev.modify_rel) begin
          mode_nxt = MODE_MOD;
        end else if (ev.mode_rel) begin
          mode_nxt = MODE_SC;
        end else begin
          mode_nxt = MODE_HM;
        end
      end
    endcase
  end

  // Setting buttons act only in modify mode and then refresh the display.
  always_comb begin
    set.hour_step   = (mode_nxt == MODE_MOD) && ev.hour_rel;
    set.minute_step = (mode_nxt == MODE_MOD) && ev.minute_rel;
    set.show_sc     = (mode_nxt == MODE_SC);
    set.show_hm     = (mode_nxt == MODE_HM) || set.hour_step || set.minute_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HM;
    end else if (adv) begin
      mode_r <= mode_nxt;
    end
  end

  // Modify mode is left only through a modify release.
  a_mod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (mode_r == MODE_MOD) && !ev.modify_rel) |=> (mode_r == MODE_MOD))
    else $error("left modify mode without a modify release");

endmodule

### hdl/dclk_disp.sv
// Display register: hours:minutes or seconds:centiseconds as a four-digit value.
// Depends on dclk_pkg.

module dclk_disp
  import dclk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  set_t        set,
  input  tod_t        tod_nxt,
  output logic [13:0] disp_nxt
);

  logic [13:0] disp_r;

  // Pick the refreshed value, or hold in modify mode with no button.
  always_comb begin
    if (set.show_sc) begin
      disp_nxt = pair100(tod_nxt.seconds, div10(tod_nxt.millis));
    end else if (set.show_hm) begin
      disp_nxt = pair100({1'b0, tod_nxt.hours}, {1'b0, tod_nxt.minutes});
    end else begin
      disp_nxt = disp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r <= '0;
    end else if (adv) begin
      disp_r <= disp_nxt;
    end
  end

  // A shown value never exceeds four digits.
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    disp_r <= 14'd9999)
    else $error("display value beyond four digits");

endmodule

### hdl/digital_clock_with_modes_top.sv
// Top level of the digital clock: input register, update logic, result register.
// Depends on dclk_pkg, dclk_time, dclk_mode and dclk_disp.
//
//  Channel | Direction | Data                          | Handshake
//  in_     | slave     | in_tdata[7:0], five flags     | in_tvalid / in_tready
//  out_    | master    | out_tdata[47:0], clock view   | out_tvalid / out_tready
//
// One beat is accepted per cycle while out_tready stays high, and one result
// beat leaves per input beat. An accepted beat waits in the input register
// until the update logic writes the state and the result register.
// While the result register is full and out_tready is low, the input register
// holds its beat and in_tready drops once it is occupied.
// Reset clears all time counters, the mode, the colon and the display.

module digital_clock_with_modes_top
  import dclk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [0] tick, [1] mode_release, [2] modify_release, [3] hour_release,
  // [4] minute_release, [7:5] zero
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [13:0] display_value, [14] colon_on, [16:15] view_mode, [21:17] hours_now,
  // [27:22] minutes_now, [33:28] seconds_now, [43:34] millis_now, [47:44] zero
  output logic [OUT_W-1:0] out_tdata
);

  logic             s1_valid_r;
  ev_t              s1_ev_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             adv;

  mode_t       mode_nxt;
  set_t        set;
  tod_t        tod_nxt;
  logic        colon_nxt;
  logic [13:0] disp_nxt;

  // A held beat is processed when the result register is free or draining.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ev_r.tick       <= in_tdata[0];
      s1_ev_r.mode_rel   <= in_tdata[1];
      s1_ev_r.modify_rel <= in_tdata[2];
      s1_ev_r.hour_rel   <= in_tdata[3];
      s1_ev_r.minute_rel <= in_tdata[4];
    end
  end

  dclk_mode u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .ev       (s1_ev_r),
    .mode_nxt (mode_nxt),
    .set      (set)
  );

  dclk_time u_time (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tick      (s1_ev_r.tick),
    .set       (set),
    .tod_nxt   (tod_nxt),
    .colon_nxt (colon_nxt)
  );

  dclk_disp u_disp (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .set      (set),
    .tod_nxt  (tod_nxt),
    .disp_nxt (disp_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {4'd0, tod_nxt.millis, tod_nxt.seconds, tod_nxt.minutes,
                     tod_nxt.hours, mode_code(mode_nxt), colon_nxt, disp_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Every processed beat shows up in the result register next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed beat did not reach the result register");

endmodule
